// ===== rtl/dll_pkg.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list engine package
// Shared widths, codes, state encoding and control structs for the engine.
// ----------------------------------------------------------------------------
package dll_pkg;

    // Fixed widths of the channel payload fields.
    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;

    // Defaults for the top-level parameters.
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Command codes carried by the request channel.
    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FIRST  = 3'd0,
        CMD_INS_LAST   = 3'd1,
        CMD_INS_AFTER  = 3'd2,
        CMD_INS_BEFORE = 3'd3,
        CMD_DELETE     = 3'd4,
        CMD_SEARCH     = 3'd5
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_ALLOC,
        ST_POP,
        ST_LINK_NEW,
        ST_LINK_NBR,
        ST_LINK_CUR,
        ST_DEL_PREV,
        ST_DEL_NEXT,
        ST_DEL_FREE,
        ST_DONE
    } state_t;

    // Field write enables of the node memory.
    typedef struct packed {
        logic value;
        logic next_link;
        logic prev_link;
    } wr_en_t;

    // One result beat.
    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
    } result_t;

endpackage

// ===== rtl/dll_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list engine command channel
// Valid/ready channel carrying one command beat with its two values.
// ----------------------------------------------------------------------------
interface dll_cmd_if;
    import dll_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] target_value;
    logic signed [WORD_W-1:0] item_value;

    modport source (output valid, output cmd, output target_value, output item_value,
                    input ready);
    modport sink   (input valid, input cmd, input target_value, input item_value,
                    output ready);

endinterface

// ===== rtl/dll_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list engine response channel
// Valid/ready channel carrying one status and position beat.
// ----------------------------------------------------------------------------
interface dll_rsp_if;
    import dll_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;

    modport source (output valid, output status, output position, input ready);
    modport sink   (input valid, input status, input position, output ready);

endinterface

// ===== rtl/dll_node_mem.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list node memory
// One record per node (value, forward link, back link), one read port with a
// registered output and one write port with a write enable per field.
// ----------------------------------------------------------------------------
module dll_node_mem #(
    parameter int CAPACITY    = dll_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic [$clog2(CAPACITY)-1:0]        rd_addr,
    output logic [VALUE_WIDTH-1:0]             rd_value,
    output logic [$clog2(CAPACITY+1)-1:0]      rd_next,
    output logic [$clog2(CAPACITY+1)-1:0]      rd_prev,
    input  logic [$clog2(CAPACITY)-1:0]        wr_addr,
    input  dll_pkg::wr_en_t                    wr_en,
    input  logic [VALUE_WIDTH-1:0]             wr_value,
    input  logic [$clog2(CAPACITY+1)-1:0]      wr_next,
    input  logic [$clog2(CAPACITY+1)-1:0]      wr_prev
);
    import dll_pkg::*;

    localparam int IW       = $clog2(CAPACITY + 1);
    localparam int REC_W    = VALUE_WIDTH + 2 * IW;
    localparam int PREV_LSB = 0;
    localparam int NEXT_LSB = IW;
    localparam int VAL_LSB  = 2 * IW;

    logic [REC_W-1:0] mem [CAPACITY];
    logic [REC_W-1:0] rd_data_reg;

    // Field-wise writes; an entry is only read after it has been written.
    always_ff @(posedge clk)
    begin
        if (wr_en.value)
        begin
            mem[wr_addr][VAL_LSB +: VALUE_WIDTH] <= wr_value;
        end
        if (wr_en.next_link)
        begin
            mem[wr_addr][NEXT_LSB +: IW] <= wr_next;
        end
        if (wr_en.prev_link)
        begin
            mem[wr_addr][PREV_LSB +: IW] <= wr_prev;
        end
    end

    // Registered read; the record is valid in the cycle after its address.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_value = rd_data_reg[VAL_LSB +: VALUE_WIDTH];
    assign rd_next  = rd_data_reg[NEXT_LSB +: IW];
    assign rd_prev  = rd_data_reg[PREV_LSB +: IW];

endmodule

// ===== rtl/dll_seq.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list sequencer
// Takes a command beat, walks the list through the node memory one node per
// cycle, rewrites the affected links for inserts and deletes, and hands a result to the output.
// ----------------------------------------------------------------------------
module dll_seq #(
    parameter int CAPACITY    = dll_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    dll_cmd_if.sink                            request,
    output logic                               res_valid,
    input  logic                               res_ready,
    output dll_pkg::result_t                   result,
    output logic [$clog2(CAPACITY)-1:0]        rd_addr,
    input  logic [VALUE_WIDTH-1:0]             rd_value,
    input  logic [$clog2(CAPACITY+1)-1:0]      rd_next,
    input  logic [$clog2(CAPACITY+1)-1:0]      rd_prev,
    output logic [$clog2(CAPACITY)-1:0]        wr_addr,
    output dll_pkg::wr_en_t                    wr_en,
    output logic [VALUE_WIDTH-1:0]             wr_value,
    output logic [$clog2(CAPACITY+1)-1:0]      wr_next,
    output logic [$clog2(CAPACITY+1)-1:0]      wr_prev
);
    import dll_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    // Control registers.
    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [IW-1:0]   tail_reg, tail_next;
    logic [IW-1:0]   free_reg, free_next;
    logic [IW-1:0]   hw_reg, hw_next;
    logic [IW-1:0]   count_reg, count_next;

    // Working registers.
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [VALUE_WIDTH-1:0] item_reg, item_next;
    logic [IW-1:0]          cur_reg, cur_next;
    logic [IW-1:0]          nbr_prev_reg, nbr_prev_next;
    logic [IW-1:0]          nbr_next_reg, nbr_next_next;
    logic [IW-1:0]          new_reg, new_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    result_t                res_reg, res_next;

    logic               accept;
    cmd_t               cmd_in;
    logic signed [63:0] target_ext;
    logic signed [63:0] item_ext;
    logic               head_nil;
    logic               free_nil;
    logic               pool_full;
    logic               match;
    logic               rd_next_nil;
    logic               lookup_in;
    logic               lookup_ins;

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;
    assign cmd_in        = cmd_t'(request.cmd);
    assign target_ext    = 64'(request.target_value);
    assign item_ext      = 64'(request.item_value);

    assign head_nil    = (head_reg >= NIL);
    assign free_nil    = (free_reg >= NIL);
    assign pool_full   = (count_reg >= NIL);
    assign match       = (rd_value == key_reg);
    assign rd_next_nil = (rd_next >= NIL);
    assign lookup_in   = (cmd_in == CMD_INS_AFTER) || (cmd_in == CMD_INS_BEFORE);
    assign lookup_ins  = (cmd_reg == CMD_INS_AFTER) || (cmd_reg == CMD_INS_BEFORE);

    assign res_valid = (state_reg == ST_DONE);
    assign result    = res_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_in)
                        CMD_INS_FIRST, CMD_INS_LAST:
                            state_next = pool_full ? ST_DONE : ST_ALLOC;
                        CMD_INS_AFTER, CMD_INS_BEFORE, CMD_DELETE, CMD_SEARCH:
                            state_next = head_nil ? ST_DONE : ST_WALK;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (match)
                begin
                    unique case (cmd_reg)
                        CMD_SEARCH: state_next = ST_DONE;
                        CMD_DELETE: state_next = ST_DEL_PREV;
                        default:    state_next = pool_full ? ST_DONE : ST_ALLOC;
                    endcase
                end
                else if (rd_next_nil)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ALLOC:    state_next = free_nil ? ST_LINK_NEW : ST_POP;
            ST_POP:      state_next = ST_LINK_NEW;
            ST_LINK_NEW: state_next = head_nil ? ST_DONE : ST_LINK_NBR;
            ST_LINK_NBR: state_next = lookup_ins ? ST_LINK_CUR : ST_DONE;
            ST_LINK_CUR: state_next = ST_DONE;
            ST_DEL_PREV: state_next = ST_DEL_NEXT;
            ST_DEL_NEXT: state_next = ST_DEL_FREE;
            ST_DEL_FREE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Memory accesses and register updates for each state.
    always_comb
    begin
        cmd_next      = cmd_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        free_next     = free_reg;
        hw_next       = hw_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        item_next     = item_reg;
        cur_next      = cur_reg;
        nbr_prev_next = nbr_prev_reg;
        nbr_next_next = nbr_next_reg;
        new_next      = new_reg;
        pos_next      = pos_reg;
        res_next      = res_reg;
        rd_addr       = cur_reg[AW-1:0];
        wr_addr       = new_reg[AW-1:0];
        wr_en         = '0;
        wr_value      = item_reg;
        wr_next       = NIL;
        wr_prev       = NIL;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Latch the beat and start reading the head node.
                if (accept)
                begin
                    cmd_next  = cmd_in;
                    key_next  = lookup_in ? target_ext[VALUE_WIDTH-1:0]
                                          : item_ext[VALUE_WIDTH-1:0];
                    item_next = item_ext[VALUE_WIDTH-1:0];
                    cur_next  = head_reg;
                    pos_next  = POS_W'(1);
                    rd_addr   = head_reg[AW-1:0];
                    res_next.status   = STAT_OK;
                    res_next.position = '0;
                    unique case (cmd_in)
                        CMD_INS_FIRST, CMD_INS_LAST:
                        begin
                            if (pool_full)
                            begin
                                res_next.status = STAT_FULL;
                            end
                        end
                        CMD_INS_AFTER, CMD_INS_BEFORE, CMD_DELETE, CMD_SEARCH:
                        begin
                            if (head_nil)
                            begin
                                res_next.status = STAT_EMPTY;
                            end
                        end
                        default:
                            res_next.status = STAT_NOT_FOUND;
                    endcase
                end
            end
            ST_WALK:
            begin
                // One node per cycle: compare, or follow the forward link.
                if (match)
                begin
                    nbr_prev_next = rd_prev;
                    nbr_next_next = rd_next;
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        res_next.position = pos_reg;
                    end
                    else if (lookup_ins && pool_full)
                    begin
                        res_next.status = STAT_FULL;
                    end
                end
                else if (rd_next_nil)
                begin
                    res_next.status = STAT_NOT_FOUND;
                end
                else
                begin
                    rd_addr  = rd_next[AW-1:0];
                    cur_next = rd_next;
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            ST_ALLOC:
            begin
                // Recycled nodes first, otherwise the next never-used node.
                if (free_nil)
                begin
                    new_next = hw_reg;
                    hw_next  = hw_reg + IW'(1);
                end
                else
                begin
                    rd_addr  = free_reg[AW-1:0];
                    new_next = free_reg;
                end
            end
            ST_POP:
            begin
                free_next = rd_next;
            end
            ST_LINK_NEW:
            begin
                // Write the whole record of the new node.
                wr_en      = '{value: 1'b1, next_link: 1'b1, prev_link: 1'b1};
                count_next = count_reg + IW'(1);
                if (head_nil)
                begin
                    head_next = new_reg;
                    tail_next = new_reg;
                end
                else
                begin
                    unique case (cmd_reg)
                        CMD_INS_FIRST:  wr_next = head_reg;
                        CMD_INS_LAST:   wr_prev = tail_reg;
                        CMD_INS_AFTER:
                        begin
                            wr_prev = cur_reg;
                            wr_next = nbr_next_reg;
                        end
                        CMD_INS_BEFORE:
                        begin
                            wr_prev = nbr_prev_reg;
                            wr_next = cur_reg;
                        end
                        default:        wr_en = '0;
                    endcase
                end
            end
            ST_LINK_NBR:
            begin
                // Point the neighbour on the far side at the new node.
                unique case (cmd_reg)
                    CMD_INS_FIRST:
                    begin
                        wr_addr           = head_reg[AW-1:0];
                        wr_en.prev_link   = 1'b1;
                        wr_prev           = new_reg;
                        head_next         = new_reg;
                    end
                    CMD_INS_LAST:
                    begin
                        wr_addr           = tail_reg[AW-1:0];
                        wr_en.next_link   = 1'b1;
                        wr_next           = new_reg;
                        tail_next         = new_reg;
                    end
                    CMD_INS_AFTER:
                    begin
                        if (nbr_next_reg < NIL)
                        begin
                            wr_addr         = nbr_next_reg[AW-1:0];
                            wr_en.prev_link = 1'b1;
                            wr_prev         = new_reg;
                        end
                        else
                        begin
                            tail_next = new_reg;
                        end
                    end
                    CMD_INS_BEFORE:
                    begin
                        if (nbr_prev_reg < NIL)
                        begin
                            wr_addr         = nbr_prev_reg[AW-1:0];
                            wr_en.next_link = 1'b1;
                            wr_next         = new_reg;
                        end
                        else
                        begin
                            head_next = new_reg;
                        end
                    end
                    default:
                    begin
                        wr_en = '0;
                    end
                endcase
            end
            ST_LINK_CUR:
            begin
                // Point the matched node at the new node.
                wr_addr = cur_reg[AW-1:0];
                if (cmd_reg == CMD_INS_AFTER)
                begin
                    wr_en.next_link = 1'b1;
                    wr_next         = new_reg;
                end
                else
                begin
                    wr_en.prev_link = 1'b1;
                    wr_prev         = new_reg;
                end
            end
            ST_DEL_PREV:
            begin
                // Bypass the node from the front.
                if (nbr_prev_reg < NIL)
                begin
                    wr_addr         = nbr_prev_reg[AW-1:0];
                    wr_en.next_link = 1'b1;
                    wr_next         = nbr_next_reg;
                end
                else
                begin
                    head_next = nbr_next_reg;
                end
            end
            ST_DEL_NEXT:
            begin
                // Bypass the node from the back.
                if (nbr_next_reg < NIL)
                begin
                    wr_addr         = nbr_next_reg[AW-1:0];
                    wr_en.prev_link = 1'b1;
                    wr_prev         = nbr_prev_reg;
                end
                else
                begin
                    tail_next = nbr_prev_reg;
                end
            end
            ST_DEL_FREE:
            begin
                // Push the released node onto the free stack.
                wr_addr         = cur_reg[AW-1:0];
                wr_en.next_link = 1'b1;
                wr_next         = free_reg;
                free_next       = cur_reg;
                count_next      = count_reg - IW'(1);
            end
            ST_DONE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_INS_FIRST;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            free_reg  <= NIL;
            hw_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            hw_reg    <= hw_next;
            count_reg <= count_next;
        end
    end

    // Working registers need no reset.
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        item_reg     <= item_next;
        cur_reg      <= cur_next;
        nbr_prev_reg <= nbr_prev_next;
        nbr_next_reg <= nbr_next_next;
        new_reg      <= new_next;
        pos_reg      <= pos_next;
        res_reg      <= res_next;
    end

    // An idle engine has an empty list exactly when it holds no nodes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (head_nil == (count_reg == '0)))
        else $error("list head and node count disagree");

    // Every node handed out is either on the list or on the free stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && free_nil) |-> (count_reg == hw_reg))
        else $error("empty free stack but nodes unaccounted for");

    // The walk only ever reads real nodes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (cur_reg < NIL))
        else $error("walk reached a nil link");

    // The never-used pointer stays within the pool.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hw_reg <= NIL) && (count_reg <= hw_reg))
        else $error("allocation pointer out of range");

    // A non-zero position only comes with a successful search.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.position != '0) |-> (res_reg.status == STAT_OK))
        else $error("position reported with a failing status");

endmodule

// ===== rtl/doubly_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list engine
// Ordered list of signed values in a node pool with forward and back links.
//
//   Channel    Role    Beat contents
//   request    sink    cmd, target_value, item_value
//   response   source  status, position
//
// Insert after, insert before, delete and search walk the list to the matching
// node or its end, since the node memory gives one record per cycle along the
// forward links. Reset clears the list at once; no clearing pass.
// The result waits in an output register, so a stalled response only holds
// the engine once a second result is ready.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine #(
    parameter int CAPACITY    = dll_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dll_cmd_if.sink    request,
    dll_rsp_if.source  response
);
    import dll_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic                   res_valid;
    logic                   res_ready;
    result_t                result;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic [IW-1:0]          rd_next;
    logic [IW-1:0]          rd_prev;
    logic [AW-1:0]          wr_addr;
    wr_en_t                 wr_en;
    logic [VALUE_WIDTH-1:0] wr_value;
    logic [IW-1:0]          wr_next;
    logic [IW-1:0]          wr_prev;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    dll_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result),
        .rd_addr   (rd_addr),
        .rd_value  (rd_value),
        .rd_next   (rd_next),
        .rd_prev   (rd_prev),
        .wr_addr   (wr_addr),
        .wr_en     (wr_en),
        .wr_value  (wr_value),
        .wr_next   (wr_next),
        .wr_prev   (wr_prev)
    );

    dll_node_mem #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_node_mem (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .rd_value (rd_value),
        .rd_next  (rd_next),
        .rd_prev  (rd_prev),
        .wr_addr  (wr_addr),
        .wr_en    (wr_en),
        .wr_value (wr_value),
        .wr_next  (wr_next),
        .wr_prev  (wr_prev)
    );

    // Output register: takes a result when empty or being drained.
    assign res_ready      = !out_valid_reg || response.ready;
    assign out_valid_next = (res_valid && res_ready) || (out_valid_reg && !response.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= result;
        end
    end

    assign response.valid    = out_valid_reg;
    assign response.status   = out_res_reg.status;
    assign response.position = out_res_reg.position;

endmodule
